// ----- rtl/eslc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eslc_pkg
// Section ids, required-section bit positions and the status structs shared
// by the event log section checker modules.
// ----------------------------------------------------------------------------
package eslc_pkg;

    localparam logic [15:0] ID_PH = 16'h5048;
    localparam logic [15:0] ID_UH = 16'h5548;
    localparam logic [15:0] ID_PS = 16'h5053;
    localparam logic [15:0] ID_EH = 16'h4548;
    localparam logic [15:0] ID_MT = 16'h4D54;
    localparam logic [15:0] ID_SS = 16'h5353;
    localparam logic [15:0] ID_SW = 16'h5357;
    localparam logic [15:0] ID_UD = 16'h5544;

    // bit positions in the required-section mask
    localparam int SEEN_PH = 0;
    localparam int SEEN_UH = 1;
    localparam int SEEN_PS = 2;
    localparam int SEEN_EH = 3;
    localparam int SEEN_MT = 4;
    localparam int SEEN_W  = 5;

    localparam logic [7:0] TOTAL_MAX = 8'hFF;

    typedef struct packed {
        logic dup;
        logic overflow;
    } t_id_status;

    typedef struct packed {
        logic       missing;
        logic       order;
        logic       count;
        logic [7:0] total;
    } t_log_status;

endpackage
`default_nettype wire

// ----- rtl/eslc_id_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eslc_id_table
// Table of non-repeatable section ids seen in the current log. A parallel
// compare against the filled entries finds duplicates; new ids are appended.
// ----------------------------------------------------------------------------
module eslc_id_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_step,
    input  wire logic                i_clear,
    input  wire logic [15:0]         i_id,
    output eslc_pkg::t_id_status     o_status
);
    import eslc_pkg::*;

    localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [15:0]       r_table [TABLE_DEPTH];
    logic [FILL_W-1:0] r_fill;
    logic              r_ovf;
    logic              r_dup;

    logic [FILL_W-1:0] n_fill;
    logic              n_ovf;
    logic              n_dup;
    logic [FILL_W-1:0] fill_base;
    logic              hit;
    logic              exempt;
    logic              wr_en;

    always_comb begin
        fill_base = i_clear ? '0 : r_fill;
        exempt    = (i_id == ID_SS) || (i_id == ID_SW) || (i_id == ID_UD);
        hit       = 1'b0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            if ((FILL_W'(k) < fill_base) && (r_table[k] == i_id)) begin
                hit = 1'b1;
            end
        end
        n_fill = fill_base;
        n_ovf  = i_clear ? 1'b0 : r_ovf;
        n_dup  = i_clear ? 1'b0 : r_dup;
        wr_en  = 1'b0;
        if (!exempt) begin
            priority if (hit) begin
                n_dup = 1'b1;
            end else if (fill_base < FILL_W'(TABLE_DEPTH)) begin
                wr_en  = 1'b1;
                n_fill = fill_base + 1'b1;
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    assign o_status.dup      = n_dup;
    assign o_status.overflow = n_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_ovf  <= 1'b0;
            r_dup  <= 1'b0;
        end else if (i_step) begin
            r_fill <= n_fill;
            r_ovf  <= n_ovf;
            r_dup  <= n_dup;
        end
    end

    // entries at or above the fill count are never compared
    always_ff @(posedge i_clk) begin
        if (i_step && wr_en) begin
            r_table[fill_base[IDX_W-1:0]] <= i_id;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/eslc_status.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eslc_status
// Running log status: section position, required sections seen, error log
// mark, claimed total and order faults, with the flags they produce.
// ----------------------------------------------------------------------------
module eslc_status (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_step,
    input  wire logic                i_clear,
    input  wire logic [15:0]         i_id,
    input  wire logic [7:0]          i_severity,
    input  wire logic [7:0]          i_declared_count,
    output eslc_pkg::t_log_status    o_status
);
    import eslc_pkg::*;

    logic [7:0]        r_pos;
    logic [SEEN_W-1:0] r_seen;
    logic              r_err;
    logic [7:0]        r_claim;
    logic              r_ord12;
    logic              r_pos3;

    logic [7:0]        n_pos;
    logic [SEEN_W-1:0] n_seen;
    logic              n_err;
    logic [7:0]        n_claim;
    logic              n_ord12;
    logic              n_pos3;
    logic [7:0]        pos_base;

    always_comb begin
        pos_base = i_clear ? '0 : r_pos;
        n_seen   = i_clear ? '0 : r_seen;
        n_err    = i_clear ? 1'b0 : r_err;
        n_claim  = i_clear ? '0 : r_claim;
        n_ord12  = i_clear ? 1'b0 : r_ord12;
        n_pos3   = i_clear ? 1'b0 : r_pos3;

        n_pos = (pos_base != TOTAL_MAX) ? pos_base + 8'd1 : pos_base;

        // only the first PH and first UH carry their payload
        if (i_id == ID_PH && !n_seen[SEEN_PH]) begin
            n_claim = i_declared_count;
        end
        if (i_id == ID_UH && !n_seen[SEEN_UH]) begin
            n_err = (i_severity != 8'd0);
        end
        if (i_id == ID_PH) n_seen[SEEN_PH] = 1'b1;
        if (i_id == ID_UH) n_seen[SEEN_UH] = 1'b1;
        if (i_id == ID_PS) n_seen[SEEN_PS] = 1'b1;
        if (i_id == ID_EH) n_seen[SEEN_EH] = 1'b1;
        if (i_id == ID_MT) n_seen[SEEN_MT] = 1'b1;

        if (n_pos == 8'd1 && i_id != ID_PH) n_ord12 = 1'b1;
        if (n_pos == 8'd2 && i_id != ID_UH) n_ord12 = 1'b1;
        if (n_pos == 8'd3 && i_id != ID_PS) n_pos3  = 1'b1;
    end

    always_comb begin
        o_status.missing = !n_seen[SEEN_PH] || !n_seen[SEEN_UH] || !n_seen[SEEN_EH]
                           || (n_err && (!n_seen[SEEN_PS] || !n_seen[SEEN_MT]));
        // position 3 is judged against the current error mark
        o_status.order   = n_ord12 || (n_pos3 && n_err);
        o_status.count   = !n_seen[SEEN_PH] || (n_pos != n_claim);
        o_status.total   = n_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_seen  <= '0;
            r_err   <= 1'b0;
            r_claim <= '0;
            r_ord12 <= 1'b0;
            r_pos3  <= 1'b0;
        end else if (i_step) begin
            r_pos   <= n_pos;
            r_seen  <= n_seen;
            r_err   <= n_err;
            r_claim <= n_claim;
            r_ord12 <= n_ord12;
            r_pos3  <= n_pos3;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/event_log_section_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// event_log_section_checker
// Running validation of event log section headers, one result per header.
// ----------------------------------------------------------------------------
// One section header is taken per transfer and one status result comes back
// for it, in order. The block sustains one header per clock cycle while
// results are not stalled; each result is registered through the input
// register, then the result register. One header per cycle holds because
// the update of the log state and the parallel compare against all TABLE_DEPTH
// id table entries are both combinational between those registers. A stalled
// result holds the next header in the input register until it transfers.
// start_of_log clears all kept state before the header is counted. Headers
// that arrive without a start continue the log left behind since reset.
// ----------------------------------------------------------------------------
module event_log_section_checker #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_start_of_log,
    input  wire logic [15:0] i_section_id,
    input  wire logic [7:0]  i_severity,
    input  wire logic [7:0]  i_declared_count,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_missing_flag,
    output logic             o_order_flag,
    output logic             o_dup_flag,
    output logic             o_count_flag,
    output logic             o_table_overflow,
    output logic [7:0]       o_section_total
);
    import eslc_pkg::*;

    logic        r_in_valid;
    logic        r_in_start;
    logic [15:0] r_in_id;
    logic [7:0]  r_in_sev;
    logic [7:0]  r_in_decl;

    logic        r_out_valid;
    t_log_status r_out_log;
    t_id_status  r_out_id;

    logic        step;
    t_log_status log_status;
    t_id_status  id_status;

    // the input register moves on whenever the result register is free
    assign step    = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_start <= i_start_of_log;
            r_in_id    <= i_section_id;
            r_in_sev   <= i_severity;
            r_in_decl  <= i_declared_count;
        end
    end

    eslc_status u_status (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (step),
        .i_clear          (r_in_start),
        .i_id             (r_in_id),
        .i_severity       (r_in_sev),
        .i_declared_count (r_in_decl),
        .o_status         (log_status)
    );

    eslc_id_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_id_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_clear  (r_in_start),
        .i_id     (r_in_id),
        .o_status (id_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_log <= log_status;
            r_out_id  <= id_status;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_missing_flag   = r_out_log.missing;
    assign o_order_flag     = r_out_log.order;
    assign o_dup_flag       = r_out_id.dup;
    assign o_count_flag     = r_out_log.count;
    assign o_table_overflow = r_out_id.overflow;
    assign o_section_total  = r_out_log.total;

endmodule
`default_nettype wire

// ----- rtl/eslc_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eslc_checker
// Port-level checks on the event log section checker, bound to the top level.
// ----------------------------------------------------------------------------
module eslc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        i_start_of_log,
    input wire logic [15:0] i_section_id,
    input wire logic [7:0]  i_severity,
    input wire logic [7:0]  i_declared_count,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic        o_missing_flag,
    input wire logic        o_order_flag,
    input wire logic        o_dup_flag,
    input wire logic        o_count_flag,
    input wire logic        o_table_overflow,
    input wire logic [7:0]  o_section_total
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    // every result counts at least its own section
    a_total_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_section_total != 8'd0)
        else $error("section total is zero");

    // no missing section needs PH, UH and EH, so at least three sections
    a_missing_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_missing_flag |-> o_section_total >= 8'd3)
        else $error("required sections reported with fewer than three sections");

    // a duplicate needs two sections
    a_dup_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_dup_flag |-> o_section_total >= 8'd2)
        else $error("duplicate reported with fewer than two sections");

endmodule

bind event_log_section_checker eslc_checker u_eslc_checker (.*);
`default_nettype wire
